@@ src/sid_pkg.sv @@
// Package for the 2D segment intersection pipeline: widths, stream layout,
// and the structs passed between the front end, the dividers and the top.
// No dependencies.
`timescale 1ns / 1ps
package sid_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 32;
    // coordinate difference width
    localparam int DW  = COORD_BITS + 1;
    // cross product width
    localparam int PW  = 2 * COORD_BITS + 3;
    // magnitude of a scaled operand
    localparam int AW  = DW;
    // product and shifted numerator widths
    localparam int MW  = PW + AW;
    localparam int NW  = MW + FRAC_BITS;
    // quotient bits
    localparam int QW  = COORD_BITS + FRAC_BITS + 2;
    localparam int EW  = (QW > OUT_BITS) ? QW : OUT_BITS;
    // divider latency: input register, one stage per quotient bit, rounding
    localparam int DIV_LAT = QW + 2;
    // stream layout
    localparam int IN_BITS   = 8 * COORD_BITS;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int RES_BITS  = 1 + 2 * OUT_BITS;
    localparam int RES_W     = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                hit;
        logic [OUT_BITS-1:0] base_x;
        logic [OUT_BITS-1:0] base_y;
    } t_side;

    typedef struct packed {
        logic [MW-1:0] prod;
        logic [PW-1:0] den;
        logic          neg;
    } t_div_in;
endpackage

@@ src/sid_div.sv @@
// Pipelined restoring divider: round(prod * 2^FRAC_BITS / den), halves away
// from zero, signed result. Depends on sid_pkg.
`timescale 1ns / 1ps
module sid_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  sid_pkg::t_div_in             i_op,
    output logic [sid_pkg::OUT_BITS-1:0] o_q
);
    logic [sid_pkg::NW-1:0] r_rem [0:sid_pkg::QW];
    logic [sid_pkg::QW-1:0] r_q   [0:sid_pkg::QW];
    logic [sid_pkg::PW-1:0] r_d   [0:sid_pkg::QW];
    logic                   r_neg [0:sid_pkg::QW];
    logic [sid_pkg::OUT_BITS-1:0] r_out;

    // load numerator scaled by the fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {i_op.prod, {sid_pkg::FRAC_BITS{1'b0}}};
            r_q[0]   <= '0;
            r_d[0]   <= i_op.den;
            r_neg[0] <= i_op.neg;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < sid_pkg::QW; k++) begin : g_stage
        localparam int BITPOS = sid_pkg::QW - 1 - k;
        logic [sid_pkg::NW-1:0] sh;
        logic                   take;
        assign sh   = sid_pkg::NW'(r_d[k]) << BITPOS;
        assign take = (r_rem[k] >= sh);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= take ? (r_rem[k] - sh) : r_rem[k];
                r_q[k+1]   <= r_q[k] | (sid_pkg::QW'(take) << BITPOS);
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // round half away from zero, then apply sign
    logic                   rnd;
    logic [sid_pkg::QW-1:0] qr;
    logic [sid_pkg::EW-1:0] qe;
    assign rnd = ({r_rem[sid_pkg::QW][sid_pkg::PW-1:0], 1'b0} >= {1'b0, r_d[sid_pkg::QW]});
    assign qr  = r_q[sid_pkg::QW] + sid_pkg::QW'(rnd);
    assign qe  = r_neg[sid_pkg::QW] ? (sid_pkg::EW'(0) - sid_pkg::EW'(qr)) : sid_pkg::EW'(qr);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= qe[sid_pkg::OUT_BITS-1:0];
        end
    end

    assign o_q = r_out;
endmodule

@@ src/sid_front.sv @@
// Geometry front end: differences, cross products, case tests and divider
// operand selection over three register stages. Depends on sid_pkg.
`timescale 1ns / 1ps
module sid_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [sid_pkg::IN_W-1:0] i_data,
    output logic                     o_valid,
    output sid_pkg::t_side           o_side,
    output sid_pkg::t_div_in         o_div_x,
    output sid_pkg::t_div_in         o_div_y
);
    localparam int C = sid_pkg::COORD_BITS;
    localparam int D = sid_pkg::DW;
    localparam int P = sid_pkg::PW;
    localparam int O = sid_pkg::OUT_BITS;

    logic r_v1, r_v2, r_v3;

    // ---------------- stage 1: coordinates and differences
    logic signed [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    assign ax0 = i_data[0*C +: C];
    assign ay0 = i_data[1*C +: C];
    assign ax1 = i_data[2*C +: C];
    assign ay1 = i_data[3*C +: C];
    assign bx0 = i_data[4*C +: C];
    assign by0 = i_data[5*C +: C];
    assign bx1 = i_data[6*C +: C];
    assign by1 = i_data[7*C +: C];

    logic signed [C-1:0] r1_ax0, r1_ay0, r1_ax1, r1_ay1, r1_bx0, r1_by0, r1_bx1, r1_by1;
    logic signed [D-1:0] r1_dxa, r1_dya, r1_dxb, r1_dyb, r1_ex, r1_ey;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax0 <= ax0; r1_ay0 <= ay0; r1_ax1 <= ax1; r1_ay1 <= ay1;
            r1_bx0 <= bx0; r1_by0 <= by0; r1_bx1 <= bx1; r1_by1 <= by1;
            r1_dxa <= D'(ax1) - D'(ax0);
            r1_dya <= D'(ay1) - D'(ay0);
            r1_dxb <= D'(bx1) - D'(bx0);
            r1_dyb <= D'(by1) - D'(by0);
            r1_ex  <= D'(bx0) - D'(ax0);
            r1_ey  <= D'(by0) - D'(ay0);
        end
    end

    // ---------------- stage 2: cross products, vertical/sloped setup
    logic signed [2*D-1:0] p_den0, p_den1, p_tn0, p_tn1, p_un0, p_un1;
    assign p_den0 = r1_dxa * r1_dyb;
    assign p_den1 = r1_dya * r1_dxb;
    assign p_tn0  = r1_ex * r1_dyb;
    assign p_tn1  = r1_ey * r1_dxb;
    assign p_un0  = r1_ex * r1_dya;
    assign p_un1  = r1_ey * r1_dxa;

    logic va, vb;
    assign va = (r1_dxa == '0);
    assign vb = (r1_dxb == '0);

    logic signed [C-1:0] px, vy0, vy1, sx0, sy0, sx1, sy1, mx0, my0, mx1, my1, lo, hi;
    always_comb begin
        px  = va ? r1_ax0 : r1_bx0;
        vy0 = va ? r1_ay0 : r1_by0;
        vy1 = va ? r1_ay1 : r1_by1;
        mx0 = va ? r1_bx0 : r1_ax0;
        my0 = va ? r1_by0 : r1_ay0;
        mx1 = va ? r1_bx1 : r1_ax1;
        my1 = va ? r1_by1 : r1_ay1;
        // order the sloped segment by x
        if (mx1 < mx0) begin
            sx0 = mx1; sy0 = my1; sx1 = mx0; sy1 = my0;
        end else begin
            sx0 = mx0; sy0 = my0; sx1 = mx1; sy1 = my1;
        end
        lo = (vy0 < vy1) ? vy0 : vy1;
        hi = (vy0 < vy1) ? vy1 : vy0;
    end

    // shared-line span test and endpoint choice
    logic signed [C+1:0] sumd_x, sumd_y;
    logic        [C+1:0] sxd, syd, ext_x, ext_y;
    logic        [D-1:0] adxa, adya, adxb, adyb;
    logic                bey_y, bey_x;
    always_comb begin
        sumd_x = (C+2)'(r1_ax0) + (C+2)'(r1_ax1) - (C+2)'(r1_bx0) - (C+2)'(r1_bx1);
        sumd_y = (C+2)'(r1_ay0) + (C+2)'(r1_ay1) - (C+2)'(r1_by0) - (C+2)'(r1_by1);
        sxd    = sumd_x[C+1] ? ((C+2)'(0) - sumd_x) : sumd_x;
        syd    = sumd_y[C+1] ? ((C+2)'(0) - sumd_y) : sumd_y;
        adxa   = r1_dxa[D-1] ? (D'(0) - r1_dxa) : r1_dxa;
        adya   = r1_dya[D-1] ? (D'(0) - r1_dya) : r1_dya;
        adxb   = r1_dxb[D-1] ? (D'(0) - r1_dxb) : r1_dxb;
        adyb   = r1_dyb[D-1] ? (D'(0) - r1_dyb) : r1_dyb;
        ext_x  = (C+2)'(adxa) + (C+2)'(adxb);
        ext_y  = (C+2)'(adya) + (C+2)'(adyb);
        bey_y  = (r1_ay0 > r1_by0 && r1_ay0 > r1_by1) || (r1_ay0 < r1_by0 && r1_ay0 < r1_by1);
        bey_x  = (r1_ax0 > r1_bx0 && r1_ax0 > r1_bx1) || (r1_ax0 < r1_bx0 && r1_ax0 < r1_bx1);
    end

    logic signed [P-1:0] r2_den, r2_tn, r2_un;
    logic signed [C-1:0] r2_px, r2_lo, r2_hi, r2_sy0;
    logic signed [D-1:0] r2_dxs, r2_dys, r2_pxo, r2_dxa, r2_dya;
    logic signed [C-1:0] r2_ax0, r2_ay0, r2_ax1, r2_ay1;
    logic                r2_va, r2_vb, r2_same, r2_span, r2_in, r2_end;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_den  <= P'(p_den0) - P'(p_den1);
            r2_tn   <= P'(p_tn0) - P'(p_tn1);
            r2_un   <= P'(p_un0) - P'(p_un1);
            r2_px   <= px;
            r2_lo   <= lo;
            r2_hi   <= hi;
            r2_sy0  <= sy0;
            r2_dxs  <= D'(sx1) - D'(sx0);
            r2_dys  <= D'(sy1) - D'(sy0);
            r2_pxo  <= D'(px) - D'(sx0);
            r2_in   <= (px >= sx0) && (px <= sx1);
            r2_dxa  <= r1_dxa;
            r2_dya  <= r1_dya;
            r2_ax0  <= r1_ax0; r2_ay0 <= r1_ay0; r2_ax1 <= r1_ax1; r2_ay1 <= r1_ay1;
            r2_va   <= va;
            r2_vb   <= vb;
            r2_same <= (r1_ax0 == r1_bx0);
            r2_span <= (sxd <= ext_x) && (syd <= ext_y);
            r2_end  <= va ? bey_y : bey_x;
        end
    end

    // ---------------- stage 3: case decisions
    logic                neg3, s_hit, m_hit, sh_hit, shared;
    logic signed [P-1:0] dn, tnn, unn;
    logic signed [C+D-1:0] p_sy, p_lo, p_hi;
    logic signed [2*D-1:0] p_dp;
    logic signed [P-1:0]   ynum;
    always_comb begin
        neg3   = r2_den[P-1];
        dn     = neg3 ? (P'(0) - r2_den) : r2_den;
        tnn    = neg3 ? (P'(0) - r2_tn)  : r2_tn;
        unn    = neg3 ? (P'(0) - r2_un)  : r2_un;
        s_hit  = !r2_va && !r2_vb && (r2_den != '0) && (tnn >= 0) && (tnn <= dn)
                 && (unn >= 0) && (unn <= dn);
        p_sy   = r2_sy0 * r2_dxs;
        p_dp   = r2_dys * r2_pxo;
        p_lo   = r2_lo * r2_dxs;
        p_hi   = r2_hi * r2_dxs;
        ynum   = P'(p_sy) + P'(p_dp);
        m_hit  = (r2_va != r2_vb) && r2_in && (ynum >= P'(p_lo)) && (ynum <= P'(p_hi));
        shared = (r2_va && r2_vb && r2_same)
                 || (!r2_va && !r2_vb && (r2_den == '0) && (r2_un == '0));
        sh_hit = shared && r2_span;
    end

    logic                r3_s, r3_m, r3_sh, r3_end;
    logic signed [P-1:0] r3_dn, r3_tn;
    logic signed [D-1:0] r3_dxa, r3_dya, r3_dys, r3_pxo, r3_dxs;
    logic signed [C-1:0] r3_px, r3_sy0, r3_ax0, r3_ay0, r3_ax1, r3_ay1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_s   <= s_hit;
            r3_m   <= m_hit;
            r3_sh  <= sh_hit;
            r3_end <= r2_end;
            r3_dn  <= dn;
            r3_tn  <= tnn;
            r3_dxa <= r2_dxa; r3_dya <= r2_dya;
            r3_dys <= r2_dys; r3_pxo <= r2_pxo; r3_dxs <= r2_dxs;
            r3_px  <= r2_px;  r3_sy0 <= r2_sy0;
            r3_ax0 <= r2_ax0; r3_ay0 <= r2_ay0; r3_ax1 <= r2_ax1; r3_ay1 <= r2_ay1;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // ---------------- operand selection and scaling product
    logic signed [D-1:0] xa, ya;
    logic        [P-1:0] xb, yb, xd, yd;
    logic        [D-1:0] xam, yam;
    always_comb begin
        o_side = '0;
        xa = '0; ya = '0;
        xb = '0; yb = '0;
        xd = P'(1); yd = P'(1);
        if (r3_sh) begin
            o_side.hit    = 1'b1;
            o_side.base_x = O'(r3_end ? r3_ax1 : r3_ax0) << sid_pkg::FRAC_BITS;
            o_side.base_y = O'(r3_end ? r3_ay1 : r3_ay0) << sid_pkg::FRAC_BITS;
        end else if (r3_s) begin
            o_side.hit    = 1'b1;
            o_side.base_x = O'(r3_ax0) << sid_pkg::FRAC_BITS;
            o_side.base_y = O'(r3_ay0) << sid_pkg::FRAC_BITS;
            xa = r3_dxa; ya = r3_dya;
            xb = $unsigned(r3_tn); yb = $unsigned(r3_tn);
            xd = $unsigned(r3_dn); yd = $unsigned(r3_dn);
        end else if (r3_m) begin
            o_side.hit    = 1'b1;
            o_side.base_x = O'(r3_px) << sid_pkg::FRAC_BITS;
            o_side.base_y = O'(r3_sy0) << sid_pkg::FRAC_BITS;
            ya = r3_dys;
            yb = P'($unsigned(r3_pxo));
            yd = P'($unsigned(r3_dxs));
        end
        xam = xa[D-1] ? (D'(0) - xa) : xa;
        yam = ya[D-1] ? (D'(0) - ya) : ya;
        o_div_x.prod = sid_pkg::MW'(xam) * sid_pkg::MW'(xb);
        o_div_y.prod = sid_pkg::MW'(yam) * sid_pkg::MW'(yb);
        o_div_x.den  = xd;
        o_div_y.den  = yd;
        o_div_x.neg  = xa[D-1];
        o_div_y.neg  = ya[D-1];
    end

    assign o_valid = r_v3;
endmodule

@@ src/segment_intersection_2d.sv @@
// Top level of the 2D segment intersection pipeline: stream ports, side
// payload delay line and output register. Depends on sid_pkg, sid_front, sid_div.
`timescale 1ns / 1ps
// Tests two segments given by signed integer endpoints for a meeting point and
// returns hit with the point in signed Q16.16 (zero when there is no hit). One
// pair is taken every cycle; each result passes through the three geometry
// stages, the bit-per-stage divider (one stage per quotient bit plus load and
// rounding) and the output register. Backpressure on the output stalls the
// whole pipe.
module segment_intersection_2d (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [sid_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // hit, meet_x, meet_y, zero padding
    output logic [sid_pkg::RES_W-1:0] o_m_axis_tdata
);
    localparam int L = sid_pkg::DIV_LAT;
    localparam int O = sid_pkg::OUT_BITS;

    logic en;
    logic r_ov, r_hit;
    logic [O-1:0] r_mx, r_my;

    // advance when the output register is free or being drained
    assign en = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic              f_valid;
    sid_pkg::t_side    f_side;
    sid_pkg::t_div_in  f_dx, f_dy;

    sid_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_div_x (f_dx),
        .o_div_y (f_dy)
    );

    logic [O-1:0] qx, qy;

    sid_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_op  (f_dx),
        .o_q   (qx)
    );

    sid_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_op  (f_dy),
        .o_q   (qy)
    );

    // delay valid and side payload alongside the dividers
    logic           r_vd   [0:L-1];
    sid_pkg::t_side r_side [0:L-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= f_side;
            for (int k = 1; k < L; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_vd[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_vd[0] <= f_valid;
            for (int k = 1; k < L; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_ov <= r_vd[L-1];
        end
    end

    // add the rounded offsets to the base point
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= r_side[L-1].hit;
            r_mx  <= r_side[L-1].base_x + qx;
            r_my  <= r_side[L-1].base_y + qy;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = sid_pkg::RES_W'({r_my, r_mx, r_hit});
endmodule
